### rtl/sta_lta_event_trigger_unit_assert.svh
// assertion macros included by the trigger unit, sampled on clock, quiet during reset
`ifndef STA_LTA_EVENT_TRIGGER_UNIT_ASSERT_SVH
`define STA_LTA_EVENT_TRIGGER_UNIT_ASSERT_SVH

// same-cycle implication
`define SLET_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SLET_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/slet_pkg.sv
package slet_pkg;

   // default build
   localparam int SHORT_LEN_DEFAULT   = 5;
   localparam int LONG_LEN_DEFAULT    = 20;
   localparam int SAMPLE_BITS_DEFAULT = 16;

   // register file
   localparam int CSR_DATA_BITS  = 16;
   localparam int CSR_INDEX_BITS = 1;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_TRIGGER_LEVEL = 1'b0,
      CSR_RELEASE_LEVEL = 1'b1
   } csr_index_type;

   // Q8.8 reset levels: 3.5 and 1.0
   localparam logic [CSR_DATA_BITS-1:0] TRIGGER_LEVEL_RESET = 16'd896;
   localparam logic [CSR_DATA_BITS-1:0] RELEASE_LEVEL_RESET = 16'd256;

   // output field widths
   localparam int SHORT_SUM_BITS = 18;
   localparam int LONG_SUM_BITS  = 20;

   // fraction bits of the threshold levels
   localparam int LEVEL_FRAC_BITS = 8;

endpackage

### rtl/sta_lta_event_trigger_unit.sv
// STA/LTA event trigger. Takes one signed sample per transfer and returns one result
// per sample: the detection state, start and end pulses, a ratio-valid flag and the
// short and long window sums of absolute values. One sample can be taken every cycle
// unless the result channel stalls. Stage one (magnitude and running-sum update
// through the delay line, settled in the cycle the sample is taken) and stage two
// (threshold products and compares with the hysteresis flag) each end in a register.
// An event starts when short_avg / long_avg > trigger_level / 256 and ends when it
// drops below release_level / 256, both compared exactly by cross-multiplication;
// the ratio counts as zero until LONG_LEN samples have been seen or while the long
// sum is zero. Levels must be written through the csr port only while no sample is
// in flight, which the block does not check. No start-up pass after reset: history
// beyond the samples seen so far reads as zero via a fill count.
module sta_lta_event_trigger_unit
   import slet_pkg::*;
#(
   parameter int SHORT_LEN   = SHORT_LEN_DEFAULT,
   parameter int LONG_LEN    = LONG_LEN_DEFAULT,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,

   // sample channel
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,

   // result channel
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic                       rsp_in_event,
   output logic                       rsp_event_start,
   output logic                       rsp_event_end,
   output logic                       rsp_ratio_valid,
   output logic [SHORT_SUM_BITS-1:0]  rsp_short_sum,
   output logic [LONG_SUM_BITS-1:0]   rsp_long_sum,

   // level registers
   input  logic                       csr_wr_en,
   input  csr_index_type              csr_index,
   input  logic [CSR_DATA_BITS-1:0]   csr_wdata
);

   `include "sta_lta_event_trigger_unit_assert.svh"

   // delay line spans the longer window
   localparam int HIST_LEN = (SHORT_LEN > LONG_LEN) ? SHORT_LEN : LONG_LEN;
   localparam int CNT_BITS = $clog2(HIST_LEN + 1);
   // magnitude of the most negative sample needs all SAMPLE_BITS
   localparam int MAG_BITS = SAMPLE_BITS;
   localparam int SW = SAMPLE_BITS + $clog2(SHORT_LEN + 1);
   localparam int LW = SAMPLE_BITS + $clog2(LONG_LEN + 1);
   // level times SHORT_LEN
   localparam int TW = CSR_DATA_BITS + $clog2(SHORT_LEN + 1);
   // width that holds both sides of the cross-multiplied compare
   localparam int CW = SAMPLE_BITS + CSR_DATA_BITS + LEVEL_FRAC_BITS
                     + $clog2(SHORT_LEN + 1) + $clog2(LONG_LEN + 1);
   localparam int NUM_SCALE = LONG_LEN * (2 ** LEVEL_FRAC_BITS);
   localparam logic [TW-1:0] TRIG_SCALED_RESET = TW'(TRIGGER_LEVEL_RESET * SHORT_LEN);
   localparam logic [TW-1:0] REL_SCALED_RESET  = TW'(RELEASE_LEVEL_RESET * SHORT_LEN);

   // ---------------- level registers ----------------
   // kept premultiplied by SHORT_LEN so stage two has a single product per level
   logic [TW-1:0] trig_scaled_ff, trig_scaled_in;
   logic [TW-1:0] rel_scaled_ff,  rel_scaled_in;

   always_comb begin
      trig_scaled_in = trig_scaled_ff;
      rel_scaled_in  = rel_scaled_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_TRIGGER_LEVEL: trig_scaled_in = TW'(csr_wdata) * TW'(SHORT_LEN);
            CSR_RELEASE_LEVEL: rel_scaled_in  = TW'(csr_wdata) * TW'(SHORT_LEN);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         trig_scaled_ff <= TRIG_SCALED_RESET;
         rel_scaled_ff  <= REL_SCALED_RESET;
      end else begin
         trig_scaled_ff <= trig_scaled_in;
         rel_scaled_ff  <= rel_scaled_in;
      end
   end

   // ---------------- flow control ----------------
   logic b_valid_ff, rsp_valid_ff;
   logic out_en, b_en, accept;

   // output register frees when empty or taken; stage two frees when it can move on
   assign out_en    = !rsp_valid_ff || rsp_ready;
   assign b_en      = !b_valid_ff || out_en;
   assign req_ready = b_en;
   assign accept    = req_valid && b_en;

   // ---------------- stage one: magnitude and running sums ----------------
   logic [MAG_BITS-1:0] mag;
   logic [MAG_BITS-1:0] hist_ff [HIST_LEN];
   logic [CNT_BITS-1:0] fill_ff, fill_in;
   logic [SW-1:0]       short_acc_ff, short_acc_in;
   logic [LW-1:0]       long_acc_ff,  long_acc_in;
   logic [MAG_BITS-1:0] tap_short, tap_long;
   logic                ratio_valid_in;

   // two's complement negate; the most negative code maps onto 2^(SAMPLE_BITS-1)
   assign mag = req_sample[SAMPLE_BITS-1] ? (~req_sample + 1'b1) : req_sample;

   // samples that fell out of each window; zero until that far back has been filled
   assign tap_short = (fill_ff >= CNT_BITS'(SHORT_LEN)) ? hist_ff[SHORT_LEN-1] : '0;
   assign tap_long  = (fill_ff >= CNT_BITS'(LONG_LEN))  ? hist_ff[LONG_LEN-1]  : '0;

   assign short_acc_in   = short_acc_ff + SW'(mag) - SW'(tap_short);
   assign long_acc_in    = long_acc_ff  + LW'(mag) - LW'(tap_long);
   assign fill_in        = (fill_ff < CNT_BITS'(HIST_LEN)) ? fill_ff + 1'b1 : fill_ff;
   // long window full with this sample included
   assign ratio_valid_in = (fill_ff >= CNT_BITS'(LONG_LEN - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         short_acc_ff <= '0;
         long_acc_ff  <= '0;
      end else if (accept) begin
         fill_ff      <= fill_in;
         short_acc_ff <= short_acc_in;
         long_acc_ff  <= long_acc_in;
      end
   end

   // delay line, newest magnitude at the front
   always_ff @(posedge clock) begin
      if (accept) begin
         hist_ff[0] <= mag;
         for (int k = 1; k < HIST_LEN; k++) begin
            hist_ff[k] <= hist_ff[k-1];
         end
      end
   end

   // stage two holding registers
   logic [SW-1:0] b_short_ff;
   logic [LW-1:0] b_long_ff;
   logic          b_ratio_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (b_en) begin
         b_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         b_short_ff       <= short_acc_in;
         b_long_ff        <= long_acc_in;
         b_ratio_valid_ff <= ratio_valid_in;
      end
   end

   // ---------------- stage two: cross-multiplied compare and hysteresis ----------------
   logic [CW-1:0] num, trig_prod, rel_prod;
   logic          ratio_live, start_cond, end_cond;
   logic          detect_ff, detect_in, start_in, end_in;

   // short_sum*LONG_LEN*256 against level*SHORT_LEN*long_sum
   assign num       = CW'(b_short_ff) * CW'(NUM_SCALE);
   assign trig_prod = CW'(trig_scaled_ff) * CW'(b_long_ff);
   assign rel_prod  = CW'(rel_scaled_ff)  * CW'(b_long_ff);

   assign ratio_live = b_ratio_valid_ff && (b_long_ff != '0);
   assign start_cond = ratio_live && (num > trig_prod);
   // ratio taken as zero: it is below the release level unless that level is zero
   assign end_cond   = ratio_live ? (num < rel_prod) : (rel_scaled_ff != '0);

   always_comb begin
      detect_in = detect_ff;
      start_in  = 1'b0;
      end_in    = 1'b0;
      priority if (!detect_ff && start_cond) begin
         detect_in = 1'b1;
         start_in  = 1'b1;
      end else if (detect_ff && end_cond) begin
         detect_in = 1'b0;
         end_in    = 1'b1;
      end
   end

   logic                      rsp_in_event_ff, rsp_start_ff, rsp_end_ff, rsp_ratio_valid_ff;
   logic [SW+SHORT_SUM_BITS-1:0] short_wide;
   logic [LW+LONG_SUM_BITS-1:0]  long_wide;

   // zero-extend first so the field takes the low bits for any window width
   assign short_wide = {{SHORT_SUM_BITS{1'b0}}, b_short_ff};
   assign long_wide  = {{LONG_SUM_BITS{1'b0}}, b_long_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         detect_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (out_en) begin
         rsp_valid_ff <= b_valid_ff;
         if (b_valid_ff) begin
            detect_ff <= detect_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_en && b_valid_ff) begin
         rsp_in_event_ff    <= detect_in;
         rsp_start_ff       <= start_in;
         rsp_end_ff         <= end_in;
         rsp_ratio_valid_ff <= b_ratio_valid_ff;
         rsp_short_sum      <= short_wide[SHORT_SUM_BITS-1:0];
         rsp_long_sum       <= long_wide[LONG_SUM_BITS-1:0];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_in_event    = rsp_in_event_ff;
   assign rsp_event_start = rsp_start_ff;
   assign rsp_event_end   = rsp_end_ff;
   assign rsp_ratio_valid = rsp_ratio_valid_ff;

   // ---------------- checks ----------------
   `SLET_ASSERT_IMP(a_start_end_excl, rsp_valid && rsp_event_start, !rsp_event_end && rsp_in_event, "start pulse without event state or with end")
   `SLET_ASSERT_IMP(a_end_clears, rsp_valid && rsp_event_end, !rsp_in_event, "end pulse while event still set")
   `SLET_ASSERT_IMP(a_start_needs_window, rsp_valid && rsp_event_start, rsp_ratio_valid, "event started before long window full")
   `SLET_ASSERT_IMP(a_ready_when_empty, !rsp_valid_ff, req_ready, "sample channel stalled with empty output register")
   `SLET_ASSERT_NEXT(a_accept_loads_stage, accept && !b_valid_ff, b_valid_ff, "accepted sample lost before stage two")

endmodule

### test/sta_lta_event_trigger_unit_scoreboard.sv
`timescale 1ns / 1ps

module sta_lta_event_trigger_unit_scoreboard
   import slet_pkg::*;
#(
   parameter int SHORT_LEN   = SHORT_LEN_DEFAULT,
   parameter int LONG_LEN    = LONG_LEN_DEFAULT,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,

   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,

   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic                          rsp_in_event,
   input  logic                          rsp_event_start,
   input  logic                          rsp_event_end,
   input  logic                          rsp_ratio_valid,
   input  logic [SHORT_SUM_BITS-1:0]     rsp_short_sum,
   input  logic [LONG_SUM_BITS-1:0]      rsp_long_sum,

   input  logic                          csr_wr_en,
   input  csr_index_type                 csr_index,
   input  logic [CSR_DATA_BITS-1:0]      csr_wdata,

   output int                            fail_count,
   output int                            outstanding,
   output int                            checked_count,
   output int                            start_count,
   output int                            end_count,
   output int                            full_count
);

   localparam int HIST_DEPTH = (SHORT_LEN > LONG_LEN) ? SHORT_LEN : LONG_LEN;

   typedef struct packed {
      logic                      in_event;
      logic                      event_start;
      logic                      event_end;
      logic                      ratio_valid;
      logic [SHORT_SUM_BITS-1:0] short_sum;
      logic [LONG_SUM_BITS-1:0]  long_sum;
   } detection_type;

   // mirror of the trigger state
   longint unsigned          magnitude_line [HIST_DEPTH];
   int unsigned              line_pos;
   int unsigned              samples_seen;
   longint unsigned          short_total;
   longint unsigned          long_total;
   logic                     detecting;
   logic [CSR_DATA_BITS-1:0] trigger_level;
   logic [CSR_DATA_BITS-1:0] release_level;

   detection_type expected_q [$];
   int mismatches;
   int checked;
   int starts;
   int ends;
   int full_windows;

   function automatic detection_type predict_detection(logic [SAMPLE_BITS-1:0] raw);
      logic [SAMPLE_BITS:0] wide;
      longint unsigned      mag;
      longint unsigned      num;
      longint unsigned      den;
      int unsigned          short_drop;
      int unsigned          long_drop;
      detection_type        r;
      wide = {raw[SAMPLE_BITS-1], raw};
      if (raw[SAMPLE_BITS-1]) begin
         wide = -wide;
      end
      mag = wide;
      short_drop = (line_pos + HIST_DEPTH - SHORT_LEN) % HIST_DEPTH;
      long_drop  = (line_pos + HIST_DEPTH - LONG_LEN) % HIST_DEPTH;
      short_total = short_total + mag - magnitude_line[short_drop];
      long_total  = long_total + mag - magnitude_line[long_drop];
      magnitude_line[line_pos] = mag;
      line_pos = (line_pos + 1) % HIST_DEPTH;
      if (samples_seen < LONG_LEN) begin
         samples_seen++;
      end
      r = '0;
      r.ratio_valid = (samples_seen >= LONG_LEN);
      // ratio compared by cross-multiplication, zero until full or on empty long sum
      if (r.ratio_valid && long_total != 0) begin
         num = (short_total * LONG_LEN) << LEVEL_FRAC_BITS;
         den = long_total * SHORT_LEN;
      end else begin
         num = 0;
         den = 1;
      end
      if (!detecting && num > trigger_level * den) begin
         detecting = 1'b1;
         r.event_start = 1'b1;
      end else if (detecting && num < release_level * den) begin
         detecting = 1'b0;
         r.event_end = 1'b1;
      end
      r.in_event  = detecting;
      r.short_sum = short_total[SHORT_SUM_BITS-1:0];
      r.long_sum  = long_total[LONG_SUM_BITS-1:0];
      return r;
   endfunction

   always @(posedge clock) begin
      detection_type want;
      detection_type got;
      if (reset) begin
         for (int k = 0; k < HIST_DEPTH; k++) begin
            magnitude_line[k] = 0;
         end
         line_pos      = 0;
         samples_seen  = 0;
         short_total   = 0;
         long_total    = 0;
         detecting     = 1'b0;
         trigger_level = TRIGGER_LEVEL_RESET;
         release_level = RELEASE_LEVEL_RESET;
         expected_q.delete();
         mismatches    = 0;
         checked       = 0;
         starts        = 0;
         ends          = 0;
         full_windows  = 0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_TRIGGER_LEVEL: trigger_level = csr_wdata;
               CSR_RELEASE_LEVEL: release_level = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            expected_q.insert(expected_q.size(), predict_detection(req_sample));
         end
         if (rsp_valid && rsp_ready) begin
            got.in_event    = rsp_in_event;
            got.event_start = rsp_event_start;
            got.event_end   = rsp_event_end;
            got.ratio_valid = rsp_ratio_valid;
            got.short_sum   = rsp_short_sum;
            got.long_sum    = rsp_long_sum;
            if (expected_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("unexpected result transfer: event=%0b short=%0d long=%0d",
                           got.in_event, got.short_sum, got.long_sum);
               end
            end else begin
               want = expected_q.pop_front();
               checked++;
               if (want.event_start) starts++;
               if (want.event_end) ends++;
               if (want.ratio_valid) full_windows++;
               if (got.in_event !== want.in_event || got.event_start !== want.event_start ||
                   got.event_end !== want.event_end || got.ratio_valid !== want.ratio_valid ||
                   got.short_sum !== want.short_sum || got.long_sum !== want.long_sum) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("result %0d: expected event=%0b start=%0b end=%0b valid=%0b %s",
                              checked, want.in_event, want.event_start, want.event_end,
                              want.ratio_valid, $sformatf("short=%0d long=%0d",
                              want.short_sum, want.long_sum));
                     $display("result %0d:   actual event=%0b start=%0b end=%0b valid=%0b %s",
                              checked, got.in_event, got.event_start, got.event_end,
                              got.ratio_valid, $sformatf("short=%0d long=%0d",
                              got.short_sum, got.long_sum));
                  end
               end
            end
         end
      end
      fail_count    <= mismatches;
      outstanding   <= expected_q.size();
      checked_count <= checked;
      start_count   <= starts;
      end_count     <= ends;
      full_count    <= full_windows;
   end

endmodule

### test/sta_lta_event_trigger_unit_tb.sv
`timescale 1ns / 1ps

module sta_lta_event_trigger_unit_tb;
   import slet_pkg::*;

   localparam int SHORT_LEN     = SHORT_LEN_DEFAULT;
   localparam int LONG_LEN      = LONG_LEN_DEFAULT;
   localparam int SAMPLE_BITS   = SAMPLE_BITS_DEFAULT;
   // spare cycles after the last result is back
   localparam int SETTLE_CYCLES = 6;
   // guard against a hung run, with a wide margin over the expected run length
   localparam int CYCLE_LIMIT   = 200000;
   localparam int HOLD_CYCLES   = 64;

   logic                          clock;
   logic                          reset           = 1'b1;
   logic                          req_valid       = 1'b0;
   logic                          req_ready;
   logic signed [SAMPLE_BITS-1:0] req_sample      = '0;
   logic                          rsp_valid;
   logic                          rsp_ready       = 1'b0;
   logic                          rsp_in_event;
   logic                          rsp_event_start;
   logic                          rsp_event_end;
   logic                          rsp_ratio_valid;
   logic [SHORT_SUM_BITS-1:0]     rsp_short_sum;
   logic [LONG_SUM_BITS-1:0]      rsp_long_sum;
   logic                          csr_wr_en       = 1'b0;
   csr_index_type                 csr_index       = CSR_TRIGGER_LEVEL;
   logic [CSR_DATA_BITS-1:0]      csr_wdata       = '0;

   int fail_count;
   int outstanding;
   int checked_count;
   int start_count;
   int end_count;
   int full_count;

   // knobs and counters for the stimulus, the result-side process and the run guard
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned hold_request  = 0;
   int unsigned samples_sent  = 0;
   int unsigned settings_used = 0;
   int unsigned cycle_count   = 0;

   sta_lta_event_trigger_unit #(
      .SHORT_LEN   (SHORT_LEN),
      .LONG_LEN    (LONG_LEN),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_sample      (req_sample),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_in_event    (rsp_in_event),
      .rsp_event_start (rsp_event_start),
      .rsp_event_end   (rsp_event_end),
      .rsp_ratio_valid (rsp_ratio_valid),
      .rsp_short_sum   (rsp_short_sum),
      .rsp_long_sum    (rsp_long_sum),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   // watches both channels and the level writes, predicts and compares
   sta_lta_event_trigger_unit_scoreboard #(
      .SHORT_LEN   (SHORT_LEN),
      .LONG_LEN    (LONG_LEN),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) scoreboard (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_sample      (req_sample),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_in_event    (rsp_in_event),
      .rsp_event_start (rsp_event_start),
      .rsp_event_end   (rsp_event_end),
      .rsp_ratio_valid (rsp_ratio_valid),
      .rsp_short_sum   (rsp_short_sum),
      .rsp_long_sum    (rsp_long_sum),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .fail_count      (fail_count),
      .outstanding     (outstanding),
      .checked_count   (checked_count),
      .start_count     (start_count),
      .end_count       (end_count),
      .full_count      (full_count)
   );

   // 2 ns clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // run guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still due", cycle_count, outstanding);
         $display("Regression FAIL");
         $finish;
      end
   end

   // result side: random stalls, or a long hold-off when the stimulus asks for one
   initial begin
      int unsigned hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left != 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   // one sample transfer, with a random gap ahead of it; valid stays high
   // on return so back-to-back samples never drop it
   task automatic send_sample(input logic [SAMPLE_BITS-1:0] value);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= value;
      do @(posedge clock); while (!req_ready);
      samples_sent++;
   endtask

   // drop valid and let every result come back before touching the levels
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_levels(input logic [CSR_DATA_BITS-1:0] trigger,
                             input logic [CSR_DATA_BITS-1:0] release_lvl);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_TRIGGER_LEVEL;
      csr_wdata <= trigger;
      @(posedge clock);
      csr_index <= CSR_RELEASE_LEVEL;
      csr_wdata <= release_lvl;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   // mostly seismic-like episodes: quiet background noise followed by a
   // loud burst, which is what drives the ratio across the levels;
   // the rest is full-range noise and runs of silence
   task automatic drive_episodes(input int unsigned budget);
      int unsigned              sent;
      int unsigned              kind;
      int unsigned              span;
      int unsigned              amp;
      int unsigned              mag;
      int                       value;
      logic [SAMPLE_BITS-1:0]   word;
      sent = 0;
      while (sent < budget) begin
         kind = $urandom_range(0, 9);
         if (kind <= 6) begin
            amp  = $urandom_range(0, 300);
            span = $urandom_range(12, 36);
            for (int k = 0; k < span; k++) begin
               value = int'($urandom_range(0, 2 * amp)) - int'(amp);
               send_sample(value[SAMPLE_BITS-1:0]);
            end
            sent += span;
            amp  = $urandom_range(4000, 32767);
            span = $urandom_range(2, 10);
            for (int k = 0; k < span; k++) begin
               mag   = $urandom_range(amp / 2, amp);
               value = $urandom_range(0, 1) ? -int'(mag) : int'(mag);
               // now and then the most negative code
               if ($urandom_range(0, 7) == 0) begin
                  value = -(1 << (SAMPLE_BITS - 1));
               end
               send_sample(value[SAMPLE_BITS-1:0]);
            end
            sent += span;
         end else if (kind <= 8) begin
            span = $urandom_range(5, 20);
            for (int k = 0; k < span; k++) begin
               word = SAMPLE_BITS'($urandom);
               send_sample(word);
            end
            sent += span;
         end else begin
            // silence long enough to empty the long window
            span = $urandom_range(LONG_LEN, LONG_LEN + 10);
            for (int k = 0; k < span; k++) begin
               send_sample('0);
            end
            sent += span;
         end
      end
   endtask

   initial begin
      logic [SAMPLE_BITS-1:0] corner;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (int phase = 0; phase < 6; phase++) begin
         // idling: sender light and receiver heavy, then swapped, then none
         case (phase)
            0, 1: begin
               send_idle_pct = 18;
               recv_idle_pct = 46;
            end
            2, 3: begin
               send_idle_pct = 46;
               recv_idle_pct = 18;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase

         // phase 0 runs on the reset levels
         case (phase)
            1: set_levels('0, '0);
            2: set_levels('1, '1);
            3: set_levels(CSR_DATA_BITS'($urandom_range(300, 1100)),
                          CSR_DATA_BITS'($urandom_range(0, 600)));
            4: set_levels('0, '1);
            5: set_levels(TRIGGER_LEVEL_RESET, RELEASE_LEVEL_RESET);
            default: ;
         endcase
         settings_used++;

         if (phase == 0) begin
            // extremes while the window fills, silence, then full-scale negatives
            for (int k = 0; k < 25; k++) begin
               case (k)
                  0: corner = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
                  1: corner = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};
                  2: corner = '1;
                  3: corner = SAMPLE_BITS'(1);
                  4: corner = {(SAMPLE_BITS / 2){2'b01}};
                  5: corner = {(SAMPLE_BITS / 2){2'b10}};
                  default: begin
                     corner = (k < 20) ? '0 : {1'b1, {(SAMPLE_BITS - 1){1'b0}}};
                  end
               endcase
               send_sample(corner);
            end
            drive_episodes(40);
         end else if (phase == 4) begin
            // receiver holds off while samples keep coming, so the block backs up
            hold_request = HOLD_CYCLES;
            drive_episodes(30);
            hold_request = HOLD_CYCLES;
            drive_episodes(30);
         end else begin
            drive_episodes((phase <= 2) ? 35 : 55);
         end
         wait_idle();
      end

      if (outstanding != 0) begin
         $display("%0d results never arrived", outstanding);
      end
      $display("covered %0d samples under %0d level settings, %0d results checked",
               samples_sent, settings_used, checked_count);
      $display("%0d events started, %0d ended, %0d results with a full long window",
               start_count, end_count, full_count);
      if (fail_count == 0 && outstanding == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
